FILE: rtl/core/cdsu_pkg.sv
// ----------------------------------------------------------------------------
// cdsu_pkg: shared types and constants
// Request layouts, pipeline records and the cordic arctangent table of the
// complex divide / square root unit.
// ----------------------------------------------------------------------------
package cdsu_pkg;

  // request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // restoring divider steps, one quotient bit each
  localparam int DIV_STEPS = 32;

  // square root input widths (|a|^2 * 16 and |a| * 2^16)
  localparam int ISQ1_W = 36;
  localparam int ISQ2_W = 34;

  // cordic datapath width
  localparam int CW = 36;

  localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [CW-1:0] PI_Q30       = 36'sd3373259426;
  localparam logic [31:0]          SAT_MAX      = 32'h7fffffff;
  localparam logic [31:0]          SAT_MIN      = 32'h80000000;

  // classified request with its products
  typedef struct packed {
    logic               act;
    logic signed [15:0] ar;
    logic signed [15:0] ai;
    logic signed [31:0] p_rr;
    logic signed [31:0] p_ii;
    logic signed [31:0] p_ir;
    logic signed [31:0] p_ri;
    logic signed [31:0] p_br;
    logic signed [31:0] p_bi;
  } front_item_t;

  // data that rides along the square root stages
  typedef struct packed {
    logic               act;
    logic signed [15:0] ar;
    logic signed [15:0] ai;
  } side_t;

  // one divider step for both parts
  typedef struct packed {
    logic [31:0] rem_r;
    logic [31:0] quo_r;
    logic [31:0] sh_r;
    logic [31:0] rem_i;
    logic [31:0] quo_i;
    logic [31:0] sh_i;
    logic [31:0] dvs;
    logic        neg_r;
    logic        neg_i;
    logic        big_r;
    logic        big_i;
    logic        zd;
  } div_step_t;

  // finished divide result
  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        zdiv;
    logic        ovf;
  } div_res_t;

  // atan(2^-i) in radians, 30 fractional bits
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/cdsu_front.sv
// ----------------------------------------------------------------------------
// cdsu_front: request intake
// Takes a request, trims the operands, classifies the action and forms the
// six partial products; holds one request until the queue takes it.
// ----------------------------------------------------------------------------
module cdsu_front #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic signed [15:0]    a_real,
  input  logic signed [15:0]    a_imag,
  input  logic signed [15:0]    b_real,
  input  logic signed [15:0]    b_imag,
  input  logic                  q_full,
  output logic                  push,
  output cdsu_pkg::front_item_t item
);
  import cdsu_pkg::*;

  localparam int OW = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam int SH = 16 - OW;

  logic               fv;
  logic               accept;
  logic signed [15:0] ar_s, ai_s, br_s, bi_s;
  logic signed [15:0] ar_x, ai_x, br_x, bi_x;
  logic signed [15:0] br_c, bi_c;

  // keep the low operand bits as two's complement
  assign ar_s = a_real <<< SH;
  assign ai_s = a_imag <<< SH;
  assign br_s = b_real <<< SH;
  assign bi_s = b_imag <<< SH;
  assign ar_x = ar_s >>> SH;
  assign ai_x = ai_s >>> SH;
  assign br_x = br_s >>> SH;
  assign bi_x = bi_s >>> SH;

  // square root reuses the divide products with b taken as a
  assign br_c = action ? ar_x : br_x;
  assign bi_c = action ? ai_x : bi_x;

  // handshake
  assign push     = fv && !q_full;
  assign in_stall = fv && q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  // products register
  always_ff @(posedge clk) begin
    if (accept) begin
      item.act  <= action;
      item.ar   <= ar_x;
      item.ai   <= ai_x;
      item.p_rr <= ar_x * br_c;
      item.p_ii <= ai_x * bi_c;
      item.p_ir <= ai_x * br_c;
      item.p_ri <= ar_x * bi_c;
      item.p_br <= br_c * br_c;
      item.p_bi <= bi_c * bi_c;
    end
  end

endmodule

FILE: rtl/core/cdsu_queue.sv
// ----------------------------------------------------------------------------
// cdsu_queue: request queue
// Small first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module cdsu_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cdsu_pkg::front_item_t din,
  input  logic                  pop,
  output cdsu_pkg::front_item_t dout,
  output logic                  full,
  output logic                  empty
);
  import cdsu_pkg::*;

  front_item_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   cnt;
  logic [QPTR_W:0]   cnt_next;

  assign full  = (cnt == (QPTR_W + 1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem[rptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  // occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_next = cnt + 1'b1;
      2'b01:   cnt_next = cnt - 1'b1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      cnt <= cnt_next;
    end
  end

endmodule

FILE: rtl/core/cdsu_isqrt.sv
// ----------------------------------------------------------------------------
// cdsu_isqrt: pipelined integer square root
// Floor square root, one root bit per stage, with a sideband that travels
// in step with the value.
// ----------------------------------------------------------------------------
module cdsu_isqrt #(
  parameter int IN_W   = 36,
  parameter int SIDE_W = 33
) (
  input  logic                clk,
  input  logic                adv,
  input  logic [IN_W-1:0]     val,
  input  logic [SIDE_W-1:0]   side_in,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int NS    = IN_W / 2;
  localparam int REM_W = NS + 3;

  logic [REM_W-1:0]  rem_q  [NS];
  logic [NS-1:0]     root_q [NS];
  logic [IN_W-1:0]   rest_q [NS];
  logic [SIDE_W-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [NS-1:0]     root_in;
    logic [IN_W-1:0]   rest_in;
    logic [SIDE_W-1:0] side_pre;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in   = '0;
      assign root_in  = '0;
      assign rest_in  = val;
      assign side_pre = side_in;
    end else begin : g_next
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign rest_in  = rest_q[k-1];
      assign side_pre = side_q[k-1];
    end

    // bring down two bits and try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rest_in[IN_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[NS-2:0], ge};
        rest_q[k] <= {rest_in[IN_W-3:0], 2'b00};
        side_q[k] <= side_pre;
      end
    end
  end

  assign root     = root_q[NS-1];
  assign side_out = side_q[NS-1];

endmodule

FILE: rtl/core/cdsu_back.sv
// ----------------------------------------------------------------------------
// cdsu_back: execution pipeline
// Divide lane (restoring divider and saturation) beside the square root
// lane (two integer roots, gain multiply, vectoring and rotation cordic),
// merged into a registered result.
// ----------------------------------------------------------------------------
module cdsu_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  cdsu_pkg::front_item_t q_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_real,
  output logic signed [31:0]    out_imag,
  output logic                  zero_divisor,
  output logic                  overflow
);
  import cdsu_pkg::*;

  localparam int NST  = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int TOT  = 2 + ISQ1_W / 2 + ISQ2_W / 2 + 1 + 2 * NST + 1;
  localparam int DLY  = TOT - 2 - DIV_STEPS - 1 - 1;
  localparam int SW   = $bits(side_t);
  localparam int S1_W = ISQ1_W / 2;
  localparam int S2_W = ISQ2_W / 2;

  // one restoring step on both parts
  function automatic div_step_t div_step(input div_step_t c);
    div_step_t  n;
    logic [32:0] t_r, t_i, d_r, d_i;
    logic        ge_r, ge_i;
    n    = c;
    t_r  = {c.rem_r, c.sh_r[31]};
    t_i  = {c.rem_i, c.sh_i[31]};
    d_r  = t_r - {1'b0, c.dvs};
    d_i  = t_i - {1'b0, c.dvs};
    ge_r = (t_r >= {1'b0, c.dvs});
    ge_i = (t_i >= {1'b0, c.dvs});
    n.rem_r = ge_r ? d_r[31:0] : t_r[31:0];
    n.rem_i = ge_i ? d_i[31:0] : t_i[31:0];
    n.quo_r = {c.quo_r[30:0], ge_r};
    n.quo_i = {c.quo_i[30:0], ge_i};
    n.sh_r  = {c.sh_r[30:0], 1'b0};
    n.sh_i  = {c.sh_i[30:0], 1'b0};
    return n;
  endfunction

  // sign, saturate and flag one quotient: {overflow, value}
  function automatic logic [32:0] sat_part(input logic [31:0] q, input logic neg,
                                           input logic big, input logic zd);
    logic [31:0] v;
    logic        o;
    o = 1'b0;
    if (zd) begin
      v = neg ? SAT_MIN : SAT_MAX;
    end else if (neg) begin
      if (big || q > SAT_MIN) begin
        v = SAT_MIN;
        o = 1'b1;
      end else begin
        v = -q;
      end
    end else if (big || q > SAT_MAX) begin
      v = SAT_MAX;
      o = 1'b1;
    end else begin
      v = q;
    end
    return {o, v};
  endfunction

  logic [TOT-1:0] vld;
  logic           adv;

  // stage 0: sums
  logic               s0_act;
  logic signed [15:0] s0_ar, s0_ai;
  logic signed [32:0] s0_nr, s0_ni;
  logic [31:0]        s0_d;

  // stage 1: divide preparation
  side_t       s1_side;
  logic [31:0] s1_d;
  logic [31:0] s1_mag_r, s1_mag_i;
  logic        s1_neg_r, s1_neg_i, s1_big_r, s1_big_i, s1_zd;
  logic [32:0] abs_r, abs_i;

  // divide lane
  div_step_t   dinit;
  div_step_t   dstep [DIV_STEPS];
  div_res_t    dsat;
  div_res_t    dres_d [DLY];
  logic [32:0] sat_r, sat_i;

  // square root lane
  logic [S1_W-1:0] mag;
  logic [S2_W-1:0] sroot;
  logic [SW-1:0]   side1, side2;
  side_t           sd2;
  logic [S2_W+29:0] prod;
  logic signed [CW-1:0] xa, ya;

  logic signed [CW-1:0] mx, my, mz;
  logic [30:0]          mx0;
  logic                 mact;

  logic signed [CW-1:0] vx [NST];
  logic signed [CW-1:0] vy [NST];
  logic signed [CW-1:0] vz [NST];
  logic [30:0]          vx0 [NST];
  logic                 vact [NST];

  logic signed [CW-1:0] rx [NST];
  logic signed [CW-1:0] ry [NST];
  logic signed [CW-1:0] rt [NST];
  logic                 ract [NST];

  logic signed [CW-1:0] fin_x, fin_y;
  logic                 fin_act;

  // pipeline advance and occupancy
  assign adv       = !vld[TOT-1] || !out_stall;
  assign pop       = adv && !q_empty;
  assign out_valid = vld[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-2:0], !q_empty};
    end
  end

  // stage 0: numerators and |b|^2
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_act <= q_item.act;
      s0_ar  <= q_item.ar;
      s0_ai  <= q_item.ai;
      s0_nr  <= $signed({q_item.p_rr[31], q_item.p_rr})
              + $signed({q_item.p_ii[31], q_item.p_ii});
      s0_ni  <= $signed({q_item.p_ir[31], q_item.p_ir})
              - $signed({q_item.p_ri[31], q_item.p_ri});
      s0_d   <= q_item.p_br + q_item.p_bi;
    end
  end

  // stage 1: magnitudes, quotient range check, zero divisor
  assign abs_r = s0_nr[32] ? 33'(-s0_nr) : 33'(s0_nr);
  assign abs_i = s0_ni[32] ? 33'(-s0_ni) : 33'(s0_ni);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side.act <= s0_act;
      s1_side.ar  <= s0_ar;
      s1_side.ai  <= s0_ai;
      s1_d        <= s0_d;
      s1_mag_r    <= abs_r[31:0];
      s1_mag_i    <= abs_i[31:0];
      s1_neg_r    <= s0_nr[32];
      s1_neg_i    <= s0_ni[32];
      s1_big_r    <= ({16'h0, abs_r[31:0]} >= {s0_d, 16'h0});
      s1_big_i    <= ({16'h0, abs_i[31:0]} >= {s0_d, 16'h0});
      s1_zd       <= (s0_d == '0);
    end
  end

  // divider entry: high dividend half as first remainder
  always_comb begin
    dinit.rem_r = {16'h0, s1_mag_r[31:16]};
    dinit.rem_i = {16'h0, s1_mag_i[31:16]};
    dinit.quo_r = '0;
    dinit.quo_i = '0;
    dinit.sh_r  = {s1_mag_r[15:0], 16'h0};
    dinit.sh_i  = {s1_mag_i[15:0], 16'h0};
    dinit.dvs   = s1_d;
    dinit.neg_r = s1_neg_r;
    dinit.neg_i = s1_neg_i;
    dinit.big_r = s1_big_r;
    dinit.big_i = s1_big_i;
    dinit.zd    = s1_zd;
  end

  // divider steps
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          dstep[j] <= div_step(dinit);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          dstep[j] <= div_step(dstep[j-1]);
        end
      end
    end
  end

  // saturation and delay to the merge stage
  assign sat_r = sat_part(dstep[DIV_STEPS-1].quo_r, dstep[DIV_STEPS-1].neg_r,
                          dstep[DIV_STEPS-1].big_r, dstep[DIV_STEPS-1].zd);
  assign sat_i = sat_part(dstep[DIV_STEPS-1].quo_i, dstep[DIV_STEPS-1].neg_i,
                          dstep[DIV_STEPS-1].big_i, dstep[DIV_STEPS-1].zd);

  always_ff @(posedge clk) begin
    if (adv) begin
      dsat.re   <= sat_r[31:0];
      dsat.im   <= sat_i[31:0];
      dsat.zdiv <= dstep[DIV_STEPS-1].zd;
      dsat.ovf  <= sat_r[32] || sat_i[32];
    end
  end

  for (genvar k = 0; k < DLY; k++) begin : g_dly
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          dres_d[k] <= dsat;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          dres_d[k] <= dres_d[k-1];
        end
      end
    end
  end

  // |a| with 16 fraction bits, then sqrt(|a|)
  cdsu_isqrt #(
    .IN_W   (ISQ1_W),
    .SIDE_W (SW)
  ) u_isqrt_mag (
    .clk      (clk),
    .adv      (adv),
    .val      ({s1_d, 4'h0}),
    .side_in  (s1_side),
    .root     (mag),
    .side_out (side1)
  );

  cdsu_isqrt #(
    .IN_W   (ISQ2_W),
    .SIDE_W (SW)
  ) u_isqrt_root (
    .clk      (clk),
    .adv      (adv),
    .val      ({mag, 16'h0}),
    .side_in  (side1),
    .root     (sroot),
    .side_out (side2)
  );

  // gain correction multiply and vectoring start point
  assign sd2  = side2;
  assign prod = (S2_W + 30)'(sroot) * (S2_W + 30)'(INV_GAIN_Q30);
  assign xa   = $signed({{(CW - 32){sd2.ar[15]}}, sd2.ar, 16'h0});
  assign ya   = $signed({{(CW - 32){sd2.ai[15]}}, sd2.ai, 16'h0});

  always_ff @(posedge clk) begin
    if (adv) begin
      mx0  <= prod[46:16];
      mact <= sd2.act;
      mx   <= sd2.ar[15] ? -xa : xa;
      my   <= sd2.ar[15] ? -ya : ya;
      if (!sd2.ar[15]) begin
        mz <= '0;
      end else begin
        mz <= sd2.ai[15] ? -PI_Q30 : PI_Q30;
      end
    end
  end

  // vectoring cordic: angle of a
  for (genvar i = 0; i < NST; i++) begin : g_vec
    logic signed [CW-1:0] cx, cy, cz, dx, dy, ta;
    logic [30:0]          cx0;
    logic                 cact;

    if (i == 0) begin : g_first
      assign cx   = mx;
      assign cy   = my;
      assign cz   = mz;
      assign cx0  = mx0;
      assign cact = mact;
    end else begin : g_next
      assign cx   = vx[i-1];
      assign cy   = vy[i-1];
      assign cz   = vz[i-1];
      assign cx0  = vx0[i-1];
      assign cact = vact[i-1];
    end

    assign dx = cy >>> i;
    assign dy = cx >>> i;
    assign ta = $signed({{(CW - 30){1'b0}}, atan_q30(5'(i))});

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cy[CW-1]) begin
          vx[i] <= cx + dx;
          vy[i] <= cy - dy;
          vz[i] <= cz + ta;
        end else begin
          vx[i] <= cx - dx;
          vy[i] <= cy + dy;
          vz[i] <= cz - ta;
        end
        vx0[i]  <= cx0;
        vact[i] <= cact;
      end
    end
  end

  // rotation cordic: root magnitude turned by half the angle
  for (genvar i = 0; i < NST; i++) begin : g_rot
    logic signed [CW-1:0] cx, cy, ct, dx, dy, ta;
    logic                 cact;

    if (i == 0) begin : g_first
      assign cx   = $signed({{(CW - 31){1'b0}}, vx0[NST-1]});
      assign cy   = '0;
      assign ct   = vz[NST-1] >>> 1;
      assign cact = vact[NST-1];
    end else begin : g_next
      assign cx   = rx[i-1];
      assign cy   = ry[i-1];
      assign ct   = rt[i-1];
      assign cact = ract[i-1];
    end

    assign dx = cy >>> i;
    assign dy = cx >>> i;
    assign ta = $signed({{(CW - 30){1'b0}}, atan_q30(5'(i))});

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!ct[CW-1]) begin
          rx[i] <= cx - dx;
          ry[i] <= cy + dy;
          rt[i] <= ct - ta;
        end else begin
          rx[i] <= cx + dx;
          ry[i] <= cy - dy;
          rt[i] <= ct + ta;
        end
        ract[i] <= cact;
      end
    end
  end

  // merge stage: output register
  assign fin_x = rx[NST-1] >>> 14;
  assign fin_y = ry[NST-1] >>> 14;

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_act <= ract[NST-1];
      if (ract[NST-1]) begin
        out_real     <= fin_x[31:0];
        out_imag     <= fin_y[31:0];
        zero_divisor <= 1'b0;
        overflow     <= 1'b0;
      end else begin
        out_real     <= dres_d[DLY-1].re;
        out_imag     <= dres_d[DLY-1].im;
        zero_divisor <= dres_d[DLY-1].zdiv;
        overflow     <= dres_d[DLY-1].ovf;
      end
    end
  end

  // square root results never carry divide flags
  a_sqrt_flags : assert property (@(posedge clk) disable iff (rst)
    out_valid && fin_act |-> !zero_divisor && !overflow)
    else $error("square root result carries a divide flag");

  // a zero divisor is reported without overflow
  a_zdiv_ovf : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(zero_divisor && overflow))
    else $error("zero divisor and overflow raised together");

  // a popped request enters the first stage
  a_pop_enter : assert property (@(posedge clk) disable iff (rst)
    pop |=> vld[0])
    else $error("popped request lost at pipeline entry");

  // a waiting result is held while the pipeline is frozen
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !adv |=> out_valid && $stable(vld))
    else $error("pipeline moved while frozen");

endmodule

FILE: rtl/core/complex_divide_sqrt_unit_top.sv
// ----------------------------------------------------------------------------
// complex_divide_sqrt_unit_top: fixed-point complex divide and square root
// Input requests carry an action and operands with 14 fraction bits;
// results come out with 16 fraction bits.
//
// Input channel: in_valid / in_stall with action, a_real, a_imag, b_real,
// b_imag. Output channel: out_valid / out_stall with out_real, out_imag,
// zero_divisor, overflow. A request moves when valid is high and stall low.
// One result leaves for every request, in request order.
// Throughput: one request per cycle while out_stall stays low.
// Path: front register, queue, 39 + 2*min(CORDIC_STAGES, 32) back stages,
// their length set by the 18 and 17 step square roots followed by the
// vectoring and rotation cordic chains; the 32-step divider beside them
// is padded with delay stages up to the merge stage.
// Reset empties the front register, the queue and all pipeline stages.
// When out_stall is high with a result waiting, the whole back pipeline holds;
// the front keeps filling the four-entry queue and raises in_stall once full.
// ----------------------------------------------------------------------------
module complex_divide_sqrt_unit_top #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [15:0] a_real,
  input  logic signed [15:0] a_imag,
  input  logic signed [15:0] b_real,
  input  logic signed [15:0] b_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_real,
  output logic signed [31:0] out_imag,
  output logic               zero_divisor,
  output logic               overflow
);
  import cdsu_pkg::*;

  front_item_t f_item;
  front_item_t q_item;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;

  // intake and products
  cdsu_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .a_real   (a_real),
    .a_imag   (a_imag),
    .b_real   (b_real),
    .b_imag   (b_imag),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  // request queue
  cdsu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_item),
    .pop   (pop),
    .dout  (q_item),
    .full  (q_full),
    .empty (q_empty)
  );

  // execution
  cdsu_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_item       (q_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_real     (out_real),
    .out_imag     (out_imag),
    .zero_divisor (zero_divisor),
    .overflow     (overflow)
  );

endmodule
